// ===== rtl/eth_ipv4_tcp_header_parser_core_defines.svh =====
// Assertion helpers
`ifndef ETH_IPV4_TCP_HEADER_PARSER_CORE_DEFINES_SVH
`define ETH_IPV4_TCP_HEADER_PARSER_CORE_DEFINES_SVH
`define EITP_ASSERT_IMPL(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error("lbl");
`define EITP_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error("lbl");
`endif

// ===== rtl/eitp_pkg.sv =====
package eitp_pkg;
    localparam int MaxFrameBytes = 65536;
    localparam int CountW = $clog2(MaxFrameBytes + 1);
    localparam int QDepth = 4;
    localparam int QAddrW = $clog2(QDepth);

    typedef enum logic [2:0] {
        PH_ETH, PH_ARP, PH_IP, PH_TCP, PH_ICMP, PH_PAYLOAD, PH_STOP
    } phase_t;

    typedef enum logic [1:0] {
        OPT_KIND, OPT_LEN, OPT_DATA, OPT_DONE
    } opt_sub_t;

    localparam logic [5:0] CODE_END = 6'd32;

    typedef struct packed {
        logic [5:0]  code;
        logic [63:0] value;
        logic [3:0]  status;
        logic        last;
    } rec_t;

    // classified record pair for one byte
    typedef struct packed {
        logic       v0;
        rec_t       r0;
        logic       v1;
        rec_t       r1;
    } pair_t;

    function automatic logic [7:0] opt_len_of(input logic [7:0] kind);
        logic [7:0] r;
        unique case (kind)
            8'd2:    r = 8'd4;
            8'd3:    r = 8'd3;
            8'd4:    r = 8'd2;
            8'd8:    r = 8'd10;
            default: r = 8'd0;
        endcase
        return r;
    endfunction
endpackage

// ===== rtl/eitp_front.sv =====
module eitp_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  logic [7:0]        data_byte,
    input  logic              frame_end,
    output eitp_pkg::pair_t   pair
);
    import eitp_pkg::*;

    logic [CountW-1:0] byte_count_reg, byte_count_next;
    logic [63:0] gather_reg, gather_next;
    phase_t      phase_reg, phase_next;
    logic [7:0]  pos_reg, pos_next;
    logic [15:0] ether_kind_reg, ether_kind_next;
    logic [5:0]  ihl_reg, ihl_next;
    logic [15:0] total_reg, total_next;
    logic [7:0]  proto_reg, proto_next;
    logic [5:0]  thl_reg, thl_next;
    logic [7:0]  icmp_type_reg, icmp_type_next;
    opt_sub_t    osub_reg, osub_next;
    logic        oerr_reg, oerr_next;
    logic [7:0]  okind_reg, okind_next;
    logic [7:0]  orem_reg, orem_next;
    logic [3:0]  perr_reg, perr_next;

    logic [7:0]  b;
    logic [63:0] g;
    logic [7:0]  pos;
    logic [6:0]  eff, eff_cur;
    logic [7:0]  left, want;
    logic [16:0] hdr_sum;
    rec_t        r0, r1;
    logic        v0, v1;
    logic [3:0]  st;
    logic [63:0] off;
    logic [5:0]  new_thl;

    always_comb
    begin
        b = data_byte;
        g = {gather_reg[55:0], b};
        pos = pos_reg;
        byte_count_next = (byte_count_reg < CountW'(MaxFrameBytes)) ?
            byte_count_reg + 1'b1 : byte_count_reg;
        pos_next = (pos_reg != 8'hFF) ? pos_reg + 8'd1 : pos_reg;
        gather_next = g;
        phase_next = phase_reg;
        ether_kind_next = ether_kind_reg;
        ihl_next = ihl_reg;
        total_next = total_reg;
        proto_next = proto_reg;
        thl_next = thl_reg;
        icmp_type_next = icmp_type_reg;
        osub_next = osub_reg;
        oerr_next = oerr_reg;
        okind_next = okind_reg;
        orem_next = orem_reg;
        perr_next = perr_reg;
        v0 = 1'b0;
        v1 = 1'b0;
        r0 = '0;
        r1 = '0;
        new_thl = {b[7:4], 2'b00};
        eff_cur = (thl_reg < 6'd20) ? 7'd20 : {1'b0, thl_reg};
        eff = eff_cur;
        left = 8'(eff) - 8'd1 - pos;
        want = opt_len_of(okind_reg);
        hdr_sum = 17'(ihl_reg) + 17'(eff_cur);
        unique case (phase_reg)
            PH_ETH:
            begin
                if (pos == 8'd5)
                begin
                    v0 = 1'b1; r0.code = 6'd0; r0.value = {16'd0, g[47:0]};
                end
                else if (pos == 8'd11)
                begin
                    v0 = 1'b1; r0.code = 6'd1; r0.value = {16'd0, g[47:0]};
                end
                else if (pos == 8'd13)
                begin
                    ether_kind_next = g[15:0];
                    v0 = 1'b1; r0.code = 6'd2; r0.value = {48'd0, g[15:0]};
                    pos_next = 8'd0;
                    if (g[15:0] == 16'h0806) phase_next = PH_ARP;
                    else if (g[15:0] == 16'h0800) phase_next = PH_IP;
                    else
                    begin
                        phase_next = PH_STOP; perr_next = 4'd2;
                    end
                end
            end
            PH_ARP:
            begin
                if (pos == 8'd1 && g[15:0] != 16'd1 && perr_reg == 4'd0)
                    perr_next = 4'd4;
                else if (pos == 8'd3 && g[15:0] != 16'h0800 && perr_reg == 4'd0)
                    perr_next = 4'd5;
                else if (pos == 8'd4 && b != 8'd6 && perr_reg == 4'd0)
                    perr_next = 4'd6;
                else if (pos == 8'd5 && b != 8'd4 && perr_reg == 4'd0)
                    perr_next = 4'd7;
                else if (pos == 8'd7)
                begin
                    v0 = 1'b1; r0.code = 6'd3; r0.value = {48'd0, g[15:0]};
                end
                else if (pos == 8'd13)
                begin
                    v0 = 1'b1; r0.code = 6'd4; r0.value = {16'd0, g[47:0]};
                end
                else if (pos == 8'd17)
                begin
                    v0 = 1'b1; r0.code = 6'd5; r0.value = {32'd0, g[31:0]};
                end
                else if (pos == 8'd23)
                begin
                    v0 = 1'b1; r0.code = 6'd6; r0.value = {16'd0, g[47:0]};
                end
                else if (pos == 8'd27)
                begin
                    v0 = 1'b1; r0.code = 6'd7; r0.value = {32'd0, g[31:0]};
                    pos_next = 8'd0;
                    phase_next = (perr_reg != 4'd0) ? PH_STOP : PH_PAYLOAD;
                end
            end
            PH_IP:
            begin
                if (pos == 8'd0) ihl_next = {b[3:0], 2'b00};
                else if (pos == 8'd3)
                begin
                    total_next = g[15:0];
                    v0 = 1'b1; r0.code = 6'd8; r0.value = {48'd0, g[15:0]};
                end
                else if (pos == 8'd5)
                begin
                    v0 = 1'b1; r0.code = 6'd9; r0.value = {48'd0, g[15:0]};
                end
                else if (pos == 8'd6)
                begin
                    v0 = 1'b1; r0.code = 6'd10; r0.value = {56'd0, b & 8'hE0};
                end
                else if (pos == 8'd7)
                begin
                    v0 = 1'b1; r0.code = 6'd11; r0.value = {51'd0, g[12:0]};
                end
                else if (pos == 8'd9)
                begin
                    proto_next = b;
                    v0 = 1'b1; r0.code = 6'd12; r0.value = {56'd0, b};
                end
                else if (pos == 8'd15)
                begin
                    v0 = 1'b1; r0.code = 6'd13; r0.value = {32'd0, g[31:0]};
                end
                else if (pos == 8'd19)
                begin
                    v0 = 1'b1; r0.code = 6'd14; r0.value = {32'd0, g[31:0]};
                end
                if (pos == 8'd19 && ihl_reg < 6'd20)
                begin
                    phase_next = PH_STOP; perr_next = 4'd8; pos_next = 8'd0;
                end
                else if (pos >= 8'd19 && pos + 8'd1 == 8'(ihl_reg))
                begin
                    pos_next = 8'd0;
                    if (proto_reg == 8'd6) phase_next = PH_TCP;
                    else if (proto_reg == 8'd1) phase_next = PH_ICMP;
                    else
                    begin
                        phase_next = PH_STOP; perr_next = 4'd9;
                    end
                end
            end
            PH_TCP:
            begin
                if (pos == 8'd12)
                begin
                    eff = (new_thl < 6'd20) ? 7'd20 : {1'b0, new_thl};
                end
                hdr_sum = 17'(ihl_reg) + 17'(eff);
                left = 8'(eff) - 8'd1 - pos;
                if (pos == 8'd1)
                begin
                    v0 = 1'b1; r0.code = 6'd15; r0.value = {48'd0, g[15:0]};
                end
                else if (pos == 8'd3)
                begin
                    v0 = 1'b1; r0.code = 6'd16; r0.value = {48'd0, g[15:0]};
                end
                else if (pos == 8'd7)
                begin
                    v0 = 1'b1; r0.code = 6'd17; r0.value = {32'd0, g[31:0]};
                end
                else if (pos == 8'd11)
                begin
                    v0 = 1'b1; r0.code = 6'd18; r0.value = {32'd0, g[31:0]};
                end
                else if (pos == 8'd12)
                begin
                    thl_next = new_thl;
                    if (new_thl < 6'd20)
                    begin
                        oerr_next = 1'b1; osub_next = OPT_DONE;
                    end
                    if (17'(total_reg) >= hdr_sum)
                    begin
                        v0 = 1'b1; r0.code = 6'd19;
                        r0.value = {47'd0, 17'(total_reg) - hdr_sum};
                    end
                end
                else if (pos == 8'd13)
                begin
                    v0 = 1'b1; r0.code = 6'd20; r0.value = {56'd0, b};
                end
                else if (pos == 8'd15)
                begin
                    v0 = 1'b1; r0.code = 6'd21; r0.value = {48'd0, g[15:0]};
                end
                if (pos >= 8'd20 && pos < 8'(eff) && osub_reg != OPT_DONE)
                begin
                    unique case (osub_reg)
                        OPT_KIND:
                        begin
                            if (b == 8'd0)
                            begin
                                if (left != 8'd0) oerr_next = 1'b1;
                                osub_next = OPT_DONE;
                            end
                            else if (b != 8'd1)
                            begin
                                if (left == 8'd0)
                                begin
                                    oerr_next = 1'b1; osub_next = OPT_DONE;
                                end
                                else
                                begin
                                    okind_next = b; osub_next = OPT_LEN;
                                end
                            end
                        end
                        OPT_LEN:
                        begin
                            if (b < 8'd2 || b - 8'd2 > left ||
                                (want != 8'd0 && b != want))
                            begin
                                oerr_next = 1'b1; osub_next = OPT_DONE;
                            end
                            else
                            begin
                                orem_next = b - 8'd2;
                                if (b == 8'd2)
                                begin
                                    osub_next = OPT_KIND;
                                    if (okind_reg == 8'd4)
                                    begin
                                        v1 = 1'b1; r1.code = 6'd24; r1.value = 64'd1;
                                    end
                                end
                                else osub_next = OPT_DATA;
                            end
                        end
                        default:
                        begin
                            orem_next = orem_reg - 8'd1;
                            if (orem_reg == 8'd1)
                            begin
                                osub_next = OPT_KIND;
                                v1 = (okind_reg == 8'd2) || (okind_reg == 8'd3) ||
                                     (okind_reg == 8'd8);
                                if (okind_reg == 8'd2)
                                begin
                                    r1.code = 6'd22; r1.value = {48'd0, g[15:0]};
                                end
                                else if (okind_reg == 8'd3)
                                begin
                                    r1.code = 6'd23; r1.value = {56'd0, b};
                                end
                                else
                                begin
                                    r1.code = 6'd25; r1.value = g;
                                end
                            end
                        end
                    endcase
                end
                if (pos >= 8'd19 && pos + 8'd1 == 8'(eff))
                begin
                    pos_next = 8'd0;
                    if (17'(total_reg) < hdr_sum)
                    begin
                        phase_next = PH_STOP; perr_next = 4'd11;
                    end
                    else phase_next = PH_PAYLOAD;
                end
            end
            PH_ICMP:
            begin
                if (pos == 8'd0)
                begin
                    icmp_type_next = b;
                    v0 = 1'b1; r0.code = 6'd26; r0.value = {56'd0, b};
                end
                else if (pos == 8'd1)
                begin
                    v0 = 1'b1; r0.code = 6'd27; r0.value = {56'd0, b};
                end
                else if (pos == 8'd4 && icmp_type_reg == 8'd12)
                begin
                    v0 = 1'b1; r0.code = 6'd31; r0.value = {56'd0, b};
                end
                else if (pos == 8'd5 && (icmp_type_reg == 8'd0 || icmp_type_reg == 8'd8))
                begin
                    v0 = 1'b1; r0.code = 6'd28; r0.value = {48'd0, g[15:0]};
                end
                else if (pos == 8'd7 && (icmp_type_reg == 8'd0 || icmp_type_reg == 8'd8))
                begin
                    v0 = 1'b1; r0.code = 6'd29; r0.value = {48'd0, g[15:0]};
                end
                else if (pos == 8'd7 && icmp_type_reg == 8'd3)
                begin
                    v0 = 1'b1; r0.code = 6'd30; r0.value = {48'd0, g[15:0]};
                end
                if (pos == 8'd7)
                begin
                    pos_next = 8'd0;
                    if (16'(ihl_reg) + 16'd8 > total_reg)
                    begin
                        phase_next = PH_STOP; perr_next = 4'd11;
                    end
                    else phase_next = PH_PAYLOAD;
                end
            end
            default:
            begin
            end
        endcase

        // end record uses state as it stood before this byte's phase change
        off = 64'd0;
        unique case (phase_reg)
            PH_ETH:  st = 4'd1;
            PH_ARP:  st = (phase_next == PH_PAYLOAD) ? 4'd0 :
                          (phase_next == PH_STOP) ? perr_next : 4'd3;
            PH_IP:   st = 4'd8;
            PH_TCP, PH_ICMP: st = 4'd10;
            PH_PAYLOAD: st = 4'd0;
            default: st = perr_reg;
        endcase
        // phases completing on this byte report as the model would after the step
        if (phase_reg != PH_ARP && phase_reg != PH_PAYLOAD && phase_reg != PH_STOP)
        begin
            if (phase_next == PH_STOP) st = perr_next;
            else if (phase_next == PH_PAYLOAD) st = 4'd0;
            else if (phase_next != phase_reg) st = (phase_next == PH_ARP) ? 4'd3 :
                (phase_next == PH_IP) ? 4'd8 : 4'd10;
        end
        if (phase_next == PH_PAYLOAD && st == 4'd0)
        begin
            if (ether_kind_next == 16'h0806) off = 64'd42;
            else if (18'(byte_count_next) < 18'd14 + 18'(total_next)) st = 4'd12;
            else if (proto_next == 8'd6)
            begin
                if (oerr_next) st = 4'd13;
                else off = 64'(7'd14 + 7'(ihl_next)) + 64'((thl_next < 6'd20) ? 7'd20 :
                           {1'b0, thl_next});
            end
            else off = 64'(7'd22 + 7'(ihl_next));
        end
        if (frame_end)
        begin
            if (!v0 && v1)
            begin
                v0 = 1'b1; r0 = r1; v1 = 1'b0;
            end
            if (!v0)
            begin
                v0 = 1'b1; r0.code = CODE_END; r0.value = off; r0.status = st;
                r0.last = 1'b1;
            end
            else
            begin
                v1 = 1'b1; r1.code = CODE_END; r1.value = off; r1.status = st;
                r1.last = 1'b1;
            end
        end
        else if (!v0 && v1)
        begin
            v0 = 1'b1; r0 = r1; v1 = 1'b0; r1 = '0;
        end
        pair.v0 = v0 & take;
        pair.r0 = r0;
        pair.v1 = v1 & take;
        pair.r1 = r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0; gather_reg <= '0; phase_reg <= PH_ETH;
            pos_reg <= '0; ether_kind_reg <= '0; ihl_reg <= '0; total_reg <= '0;
            proto_reg <= '0; thl_reg <= '0; icmp_type_reg <= '0;
            osub_reg <= OPT_KIND; oerr_reg <= 1'b0; okind_reg <= '0;
            orem_reg <= '0; perr_reg <= '0;
        end
        else if (take)
        begin
            if (frame_end)
            begin
                byte_count_reg <= '0; gather_reg <= '0; phase_reg <= PH_ETH;
                pos_reg <= '0; ether_kind_reg <= '0; ihl_reg <= '0; total_reg <= '0;
                proto_reg <= '0; thl_reg <= '0; icmp_type_reg <= '0;
                osub_reg <= OPT_KIND; oerr_reg <= 1'b0; okind_reg <= '0;
                orem_reg <= '0; perr_reg <= '0;
            end
            else
            begin
                byte_count_reg <= byte_count_next; gather_reg <= gather_next;
                phase_reg <= phase_next; pos_reg <= pos_next;
                ether_kind_reg <= ether_kind_next; ihl_reg <= ihl_next;
                total_reg <= total_next; proto_reg <= proto_next;
                thl_reg <= thl_next; icmp_type_reg <= icmp_type_next;
                osub_reg <= osub_next; oerr_reg <= oerr_next;
                okind_reg <= okind_next; orem_reg <= orem_next;
                perr_reg <= perr_next;
            end
        end
    end
endmodule

// ===== rtl/eitp_queue.sv =====
module eitp_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  eitp_pkg::pair_t pair,
    output logic            full,
    output logic            empty,
    input  logic            pop,
    output eitp_pkg::rec_t  head
);
    import eitp_pkg::*;
    `include "eth_ipv4_tcp_header_parser_core_defines.svh"

    rec_t mem_reg [QDepth];
    logic [QAddrW-1:0] wp_reg, rp_reg;
    logic [QAddrW:0]   cnt_reg, cnt_next;
    logic              do_pop;
    logic [1:0]        n_in;

    assign do_pop = pop && !empty;
    assign empty = (cnt_reg == '0);
    // room must remain for two records from one transaction
    assign full = (cnt_reg > (QAddrW+1)'(QDepth - 2));
    assign head = mem_reg[rp_reg];
    assign n_in = {1'b0, pair.v0} + {1'b0, pair.v1};
    assign cnt_next = cnt_reg + (QAddrW+1)'(n_in) - (QAddrW+1)'(do_pop);

    always_ff @(posedge clk)
    begin
        if (pair.v0) mem_reg[wp_reg] <= pair.r0;
        if (pair.v1) mem_reg[wp_reg + QAddrW'(1)] <= pair.r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end
        else
        begin
            wp_reg <= wp_reg + QAddrW'(n_in);
            rp_reg <= rp_reg + QAddrW'(do_pop);
            cnt_reg <= cnt_next;
        end
    end

    `EITP_ASSERT_IMPL(a_no_overflow, clk, rst_n, 1'b1, cnt_reg <= (QAddrW+1)'(QDepth))
    `EITP_ASSERT_IMPL(a_pair_order, clk, rst_n, pair.v1, pair.v0)
    `EITP_ASSERT_NEXT(a_pop_count, clk, rst_n, do_pop && n_in == 2'd0,
                      cnt_reg == $past(cnt_reg) - 1'b1)
endmodule

// ===== rtl/eth_ipv4_tcp_header_parser_core.sv =====
// Records enter the queue at the edge that takes the byte completing them.
// Throughput: 1 byte per cycle unless full; up to 2 records per byte into a
// 4-entry queue. Input stalls (full) while 3 or more records wait, so a
// two-record byte can stall it even while the result side drains.
// Reset: asynchronous active-low rst_n clears parse state and empties the queue.
module eth_ipv4_tcp_header_parser_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        frame_end,
    output logic        empty,
    input  logic        pop,
    output logic [5:0]  field_code,
    output logic [63:0] field_value,
    output logic [3:0]  status,
    output logic        record_last
);
    import eitp_pkg::*;

    pair_t pair;
    rec_t  head;
    logic  take;

    assign take = push && !full;

    eitp_front u_front (
        .clk(clk), .rst_n(rst_n), .take(take),
        .data_byte(data_byte), .frame_end(frame_end), .pair(pair)
    );

    eitp_queue u_queue (
        .clk(clk), .rst_n(rst_n), .pair(pair), .full(full),
        .empty(empty), .pop(pop), .head(head)
    );

    assign field_code = head.code;
    assign field_value = head.value;
    assign status = head.status;
    assign record_last = head.last;
endmodule
